FILE: rtl/kst_pkg.sv
package kst_pkg;

  localparam int unsigned CODE_W        = 31;
  localparam int unsigned DEF_ENTRIES   = 128;
  localparam int unsigned DEF_PENDING_W = 8;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_e;

  // write port of the entry memory
  typedef struct packed {
    logic en;
    logic clear;
  } wr_ctl_t;

endpackage

FILE: rtl/key_state_table.sv
// channel | handshake                  | payload
// in      | in_valid_i / in_stall_o    | opcode_i, key_code_i, pressed_i
// out     | out_valid_o / out_stall_i  | found_o, is_down_o, is_clicked_o, table_full_o
//
// every item walks all ENTRIES entries through the one-read one-write entry
// memory, one entry per cycle
// key events and queries search, ticks and release-all rewrite each entry in place
// after reset a clearing pass over all ENTRIES entries zeroes the memory, no item taken
// a finished result sits in the output register while the next item is taken
module key_state_table #(
  parameter int unsigned ENTRIES   = kst_pkg::DEF_ENTRIES,
  parameter int unsigned PENDING_W = kst_pkg::DEF_PENDING_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [kst_pkg::CODE_W-1:0] key_code_i,
  input  logic                       pressed_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic                       is_down_o,
  output logic                       is_clicked_o,
  output logic                       table_full_o
);

  localparam int unsigned AW    = $clog2(ENTRIES);
  localparam int unsigned CW    = kst_pkg::CODE_W;
  localparam int unsigned ENT_W = CW + 2 + PENDING_W;
  localparam int unsigned DOWN_B  = PENDING_W + 1;
  localparam int unsigned CLICK_B = PENDING_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [PENDING_W-1:0] PEND_MAX = '1;

  kst_pkg::state_e state_q, state_d;
  kst_pkg::wr_ctl_t wr_ctl;

  logic [AW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    waddr;
  logic [ENT_W-1:0] wdata;
  logic [ENT_W-1:0] rdata;

  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] rd_idx_q;

  kst_pkg::op_e  op_q;
  logic [CW-1:0] code_q;
  logic          pressed_q;
  logic          code_nz;

  logic          hit_q, emp_q;
  logic [AW-1:0] hit_idx_q, emp_idx_q;
  logic [ENT_W-1:0] hit_data_q;

  logic [CW-1:0]        rd_code;
  logic [PENDING_W-1:0] rd_pend_cnt;
  logic                 rd_match, rd_empty;

  logic [PENDING_W-1:0] hit_pend;
  logic [PENDING_W-1:0] new_pend;
  logic                 load_out;
  logic                 res_found, res_down, res_click, res_full;

  logic out_valid_q, found_q, is_down_q, is_clicked_q, table_full_q;

  kst_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (ENT_W),
    .AW    (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_ctl_i (wr_ctl),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_i  (cnt_q),
    .rdata_o  (rdata)
  );

  assign code_nz     = (code_q != '0);
  assign rd_code     = rdata[ENT_W-1 -: CW];
  assign rd_pend_cnt = rdata[PENDING_W-1:0];
  assign rd_match    = rd_pend_q && code_nz && (rd_code == code_q);
  assign rd_empty    = rd_pend_q && (rd_code == '0);

  assign hit_pend = hit_data_q[PENDING_W-1:0];
  always_comb begin
    if (hit_q) begin
      new_pend = (pressed_q && (hit_pend != PEND_MAX)) ? hit_pend + 1'b1 : hit_pend;
    end else begin
      new_pend = pressed_q ? PENDING_W'(1) : '0;
    end
  end

  always_comb begin
    res_found = 1'b0;
    res_down  = 1'b0;
    res_click = 1'b0;
    res_full  = 1'b0;
    unique case (op_q)
      kst_pkg::OP_KEY: begin
        if (code_nz) begin
          res_found = hit_q || emp_q;
          res_down  = (hit_q || emp_q) && pressed_q;
          res_click = hit_q && hit_data_q[CLICK_B];
          res_full  = !(hit_q || emp_q);
        end
      end
      kst_pkg::OP_QUERY: begin
        res_found = hit_q;
        res_down  = hit_q && hit_data_q[DOWN_B];
        res_click = hit_q && hit_data_q[CLICK_B];
      end
      kst_pkg::OP_TICK, kst_pkg::OP_RELEASE: begin
      end
      default: begin
      end
    endcase
  end

  // fsm: next state, read issue and write port
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_pend_d  = 1'b0;
    wr_ctl     = '0;
    waddr      = rd_idx_q;
    wdata      = rdata;
    load_out   = 1'b0;
    in_stall_o = 1'b1;

    // in-place rewrite as read data comes back
    if (rd_pend_q) begin
      if (op_q == kst_pkg::OP_TICK) begin
        wr_ctl.en = 1'b1;
        if (rd_pend_cnt != '0) begin
          wdata[CLICK_B]        = 1'b1;
          wdata[PENDING_W-1:0]  = rd_pend_cnt - 1'b1;
        end else begin
          wdata[CLICK_B] = 1'b0;
        end
      end else if (op_q == kst_pkg::OP_RELEASE) begin
        wr_ctl.en     = 1'b1;
        wdata[DOWN_B] = 1'b0;
      end
    end

    unique case (state_q)
      kst_pkg::ST_CLEAR: begin
        wr_ctl.en    = 1'b1;
        wr_ctl.clear = 1'b1;
        waddr        = cnt_q;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = kst_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      kst_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cnt_d   = '0;
          state_d = kst_pkg::ST_SCAN;
        end
      end
      kst_pkg::ST_SCAN: begin
        rd_pend_d = 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = kst_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      kst_pkg::ST_DRAIN: begin
        state_d = (op_q == kst_pkg::OP_KEY) ? kst_pkg::ST_COMMIT : kst_pkg::ST_RESP;
      end
      kst_pkg::ST_COMMIT: begin
        if (code_nz && (hit_q || emp_q)) begin
          wr_ctl.en = 1'b1;
          waddr     = hit_q ? hit_idx_q : emp_idx_q;
          wdata     = {code_q, pressed_q, hit_q && hit_data_q[CLICK_B], new_pend};
        end
        state_d = kst_pkg::ST_RESP;
      end
      kst_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = kst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kst_pkg::ST_CLEAR;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      emp_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == kst_pkg::ST_IDLE && in_valid_i) begin
        hit_q <= 1'b0;
        emp_q <= 1'b0;
      end else begin
        if (rd_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (rd_empty) begin
          emp_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (state_q == kst_pkg::ST_IDLE && in_valid_i) begin
      op_q      <= kst_pkg::op_e'(opcode_i);
      code_q    <= key_code_i;
      pressed_q <= pressed_i;
    end
    // lowest match wins, highest empty wins (ascending walk)
    if (rd_match && !hit_q) begin
      hit_idx_q  <= rd_idx_q;
      hit_data_q <= rdata;
    end
    if (rd_empty) begin
      emp_idx_q <= rd_idx_q;
    end
    if (load_out) begin
      found_q      <= res_found;
      is_down_q    <= res_down;
      is_clicked_q <= res_click;
      table_full_q <= res_full;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign is_down_o    = is_down_q;
  assign is_clicked_o = is_clicked_q;
  assign table_full_o = table_full_q;

`ifndef SYNTH
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == kst_pkg::ST_SCAN))
    else $error("accepted item did not start a scan");

  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == kst_pkg::ST_SCAN))
    else $error("read data returned outside a scan");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(table_full_o && found_o))
    else $error("result both full and found");

  a_flags_need_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (!is_down_o && !is_clicked_o))
    else $error("flags reported without an entry");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kst_pkg::ST_COMMIT) |-> !rd_pend_q)
    else $error("commit write overlaps a scan write-back");
`endif

endmodule

FILE: rtl/kst_mem.sv
module kst_mem #(
  parameter int unsigned DEPTH = kst_pkg::DEF_ENTRIES,
  parameter int unsigned WIDTH = kst_pkg::CODE_W + 2 + kst_pkg::DEF_PENDING_W,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  kst_pkg::wr_ctl_t wr_ctl_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en) begin
      mem[waddr_i] <= wr_ctl_i.clear ? '0 : wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb_key_state_table.sv
module tb_key_state_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CODE_W      = kst_pkg::CODE_W;
  localparam int unsigned ENTRIES     = kst_pkg::DEF_ENTRIES;
  localparam int unsigned PENDING_W   = kst_pkg::DEF_PENDING_W;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned FRESH_MAX   = 30;
  localparam int unsigned RAND_ITEMS  = 300;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic found;
    logic is_down;
    logic is_clicked;
    logic table_full;
  } key_resp_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [1:0]          opcode_i     = kst_pkg::OP_KEY;
  logic [CODE_W-1:0]   key_code_i   = '0;
  logic                pressed_i    = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                found_o;
  logic                is_down_o;
  logic                is_clicked_o;
  logic                table_full_o;

  // shadow copy of the key table
  logic [CODE_W-1:0]    shadow_code    [ENTRIES];
  logic                 shadow_down    [ENTRIES];
  logic                 shadow_clicked [ENTRIES];
  logic [PENDING_W-1:0] shadow_pending [ENTRIES];

  key_resp_t         resp_q[$];
  logic [CODE_W-1:0] code_pool [POOL_SIZE];
  int unsigned       error_count = 0;
  longint unsigned   cycle_count = 0;
  bit                calm        = 1'b0;

  key_state_table #(
    .ENTRIES  (ENTRIES),
    .PENDING_W(PENDING_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .key_code_i  (key_code_i),
    .pressed_i   (pressed_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .is_down_o   (is_down_o),
    .is_clicked_o(is_clicked_o),
    .table_full_o(table_full_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, resp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
  end

  task automatic report_error(string msg);
    // keep the log short if everything goes wrong
    if (error_count < 50) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic int find_code(logic [CODE_W-1:0] code);
    int hit;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && shadow_code[i] == code) hit = i;
    end
    return hit;
  endfunction

  function automatic int free_entries();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_code[i] == '0) n++;
    end
    return n;
  endfunction

  function automatic logic [CODE_W-1:0] fresh_code();
    logic [CODE_W-1:0] c;
    do begin
      c = CODE_W'($urandom);
    end while (c == '0 || find_code(c) >= 0);
    return c;
  endfunction

  // updates the shadow table and returns the answer the block must give
  function automatic key_resp_t apply_item(kst_pkg::op_e op, logic [CODE_W-1:0] code,
                                           logic pr);
    key_resp_t r;
    int hit;
    r = '0;
    hit = -1;
    case (op)
      kst_pkg::OP_KEY: begin
        if (code != '0) begin
          hit = find_code(code);
          if (hit < 0) begin
            // new code takes the highest empty slot
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (hit < 0 && shadow_code[i] == '0) hit = i;
            end
            if (hit >= 0) shadow_code[hit] = code;
          end
          if (hit >= 0) begin
            shadow_down[hit] = pr;
            if (pr && shadow_pending[hit] != '1) shadow_pending[hit]++;
            r.found      = 1'b1;
            r.is_down    = shadow_down[hit];
            r.is_clicked = shadow_clicked[hit];
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
      kst_pkg::OP_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_pending[i] != '0) begin
            shadow_pending[i]--;
            shadow_clicked[i] = 1'b1;
          end else begin
            shadow_clicked[i] = 1'b0;
          end
        end
      end
      kst_pkg::OP_RELEASE: begin
        for (int i = 0; i < ENTRIES; i++) shadow_down[i] = 1'b0;
      end
      default: begin
        if (code != '0) begin
          hit = find_code(code);
          if (hit >= 0) begin
            r.found      = 1'b1;
            r.is_down    = shadow_down[hit];
            r.is_clicked = shadow_clicked[hit];
          end
        end
      end
    endcase
    return r;
  endfunction

  // valid stays up after acceptance until the next falling edge
  task automatic send_item(kst_pkg::op_e op, logic [CODE_W-1:0] code, logic pr);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_code_i <= code;
    pressed_i  <= pr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    resp_q.push_back(apply_item(op, code, pr));
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    key_resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (resp_q.size() == 0) begin
        report_error("result with no item outstanding");
      end else begin
        want = resp_q.pop_front();
        if (found_o !== want.found)
          report_error($sformatf("found_o got %b want %b", found_o, want.found));
        if (is_down_o !== want.is_down)
          report_error($sformatf("is_down_o got %b want %b", is_down_o, want.is_down));
        if (is_clicked_o !== want.is_clicked)
          report_error($sformatf("is_clicked_o got %b want %b", is_clicked_o, want.is_clicked));
        if (table_full_o !== want.table_full)
          report_error($sformatf("table_full_o got %b want %b", table_full_o, want.table_full));
      end
    end
  end

  task automatic test_basic_ops();
    send_item(kst_pkg::OP_QUERY, 31'd5, 1'b0);
    send_item(kst_pkg::OP_KEY, '0, 1'b1);
    send_item(kst_pkg::OP_QUERY, '0, 1'b1);
    send_item(kst_pkg::OP_KEY, 31'h7FFF_FFFF, 1'b1);
    send_item(kst_pkg::OP_QUERY, 31'h7FFF_FFFF, 1'b0);
    send_item(kst_pkg::OP_TICK, 31'h7FFF_FFFF, 1'b1);
    send_item(kst_pkg::OP_QUERY, 31'h7FFF_FFFF, 1'b0);
    send_item(kst_pkg::OP_KEY, 31'd1, 1'b1);
    send_item(kst_pkg::OP_KEY, 31'd1, 1'b1);
    send_item(kst_pkg::OP_KEY, 31'd1, 1'b0);
    // key up for an unseen code still claims an entry
    send_item(kst_pkg::OP_KEY, 31'd2, 1'b0);
    send_item(kst_pkg::OP_TICK, '0, 1'b0);
    send_item(kst_pkg::OP_QUERY, 31'd1, 1'b0);
    wait_until_drained();
    send_item(kst_pkg::OP_TICK, '0, 1'b0);
    send_item(kst_pkg::OP_QUERY, 31'd1, 1'b1);
    send_item(kst_pkg::OP_TICK, '0, 1'b0);
    send_item(kst_pkg::OP_QUERY, 31'd1, 1'b0);
    send_item(kst_pkg::OP_QUERY, 31'h7FFF_FFFF, 1'b0);
    send_item(kst_pkg::OP_RELEASE, 31'h5555_5555, 1'b1);
    send_item(kst_pkg::OP_QUERY, 31'h7FFF_FFFF, 1'b0);
    send_item(kst_pkg::OP_QUERY, 31'd2, 1'b0);
  endtask

  task automatic test_pending_saturation();
    logic [CODE_W-1:0] code;
    code = fresh_code();
    repeat ((1 << PENDING_W) + 4) send_item(kst_pkg::OP_KEY, code, 1'b1);
    send_item(kst_pkg::OP_QUERY, code, 1'b0);
    // a count that wrapped would run dry within these ticks
    repeat (6) begin
      send_item(kst_pkg::OP_TICK, '0, 1'b0);
      send_item(kst_pkg::OP_QUERY, code, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned       fresh_left;
    int unsigned       roll;
    kst_pkg::op_e      op;
    logic [CODE_W-1:0] code;
    fresh_left = FRESH_MAX;
    foreach (code_pool[i]) code_pool[i] = fresh_code();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 100 && n < 220);
      roll = $urandom_range(0, 99);
      if (roll < 45) op = kst_pkg::OP_KEY;
      else if (roll < 65) op = kst_pkg::OP_TICK;
      else if (roll < 70) op = kst_pkg::OP_RELEASE;
      else op = kst_pkg::OP_QUERY;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        code = '0;
      end else if (roll < 10 && fresh_left > 0) begin
        code = fresh_code();
        if (op == kst_pkg::OP_KEY) fresh_left--;
      end else begin
        code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      send_item(op, code, 1'($urandom_range(0, 1)));
    end
    calm = 1'b0;
  endtask

  task automatic test_table_full();
    while (free_entries() > 0) begin
      send_item(kst_pkg::OP_KEY, fresh_code(), 1'($urandom_range(0, 1)));
    end
    repeat (3) send_item(kst_pkg::OP_KEY, fresh_code(), 1'b1);
    send_item(kst_pkg::OP_KEY, fresh_code(), 1'b0);
    send_item(kst_pkg::OP_QUERY, fresh_code(), 1'b0);
    // known codes keep working once the table is full
    send_item(kst_pkg::OP_KEY, code_pool[0], 1'b1);
    send_item(kst_pkg::OP_TICK, '0, 1'b0);
    send_item(kst_pkg::OP_QUERY, code_pool[0], 1'b0);
    send_item(kst_pkg::OP_KEY, '0, 1'b1);
    send_item(kst_pkg::OP_QUERY, code_pool[POOL_SIZE - 1], 1'b0);
  endtask

  initial begin
    foreach (shadow_code[i]) begin
      shadow_code[i]    = '0;
      shadow_down[i]    = 1'b0;
      shadow_clicked[i] = 1'b0;
      shadow_pending[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_pending_saturation();
    test_random_traffic();
    test_table_full();

    wait_until_drained();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/kst_pkg.sv
rtl/kst_mem.sv
rtl/key_state_table.sv
tb/tb_key_state_table.sv
